@@ design/dtf_pkg.sv @@
// shared types and constants for the decimal text to float converter
`timescale 1ns / 1ps

package dtf_pkg;

  // character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;

  // single precision constants
  localparam logic [31:0] F_ZERO  = 32'h0000_0000;
  localparam logic [31:0] F_ONE   = 32'h3F80_0000;
  localparam logic [31:0] F_TEN   = 32'h4120_0000;
  localparam logic [31:0] F_TENTH = 32'h3DCC_CCCD;
  localparam logic [31:0] F_QNAN  = 32'h7FC0_0000;

  // width of the exponent magnitude carried through the queue
  localparam int unsigned Q_MAG_W = 16;

  // command classes decided by the front end
  typedef enum logic [1:0] {
    OP_NONE,
    OP_DIGIT,
    OP_DOT,
    OP_EXP
  } q_op_t;

  // one queue entry
  typedef struct packed {
    q_op_t              op;
    logic [31:0]        digf;
    logic               last;
    logic               neg;
    logic               in_exp;
    logic               eneg;
    logic [Q_MAG_W-1:0] mag;
  } q_entry_t;

  // float unit operations
  typedef enum logic {
    FOP_MUL,
    FOP_ADD
  } fop_t;

  // float unit request
  typedef struct packed {
    logic        valid;
    fop_t        op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  // back end sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_D_ADD,
    S_D_SCL,
    S_D_END,
    S_CHK,
    S_P_LOOP,
    S_P_Y,
    S_P_X,
    S_P_END,
    S_F_ZERO,
    S_OUT
  } bk_state_t;

endpackage

@@ design/dtf_queue.sv @@
// small command queue between front and back end
`timescale 1ns / 1ps

module dtf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  dtf_pkg::q_entry_t push_data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output dtf_pkg::q_entry_t head_o
);
  import dtf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full_o  = (count_r == CW'(DEPTH));
  assign empty_o = (count_r == '0);
  assign head_o  = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

endmodule

@@ design/dtf_front.sv @@
// front end: takes characters, tracks sign and exponent, queues commands
`timescale 1ns / 1ps

module dtf_front #(
  parameter int unsigned EXP_SATURATE = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_ch,
  input  logic              in_last,
  input  logic              q_full_i,
  output logic              q_push_o,
  output dtf_pkg::q_entry_t q_data_o
);
  import dtf_pkg::*;

  localparam int unsigned MAG_W = $clog2(EXP_SATURATE + 1);
  localparam int unsigned MW    = MAG_W + 6;
  localparam logic signed [MW-1:0] SAT_S = MW'(EXP_SATURATE);

  logic             neg_r, neg_nxt;
  logic             in_exp_r, in_exp_nxt;
  logic             eneg_r, eneg_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;

  logic signed [8:0]    digit;
  logic [7:0]           digit_abs;
  logic [2:0]           msb;
  logic [23:0]          frac_sh;
  logic [31:0]          digf;
  logic [MW-1:0]        mag_ext;
  logic signed [MW-1:0] m_calc;
  logic [MAG_W-1:0]     mag_upd;
  logic                 accept;
  q_op_t                op;

  assign in_stall = q_full_i;
  assign accept   = in_valid && !q_full_i;

  // digit value and its exact float form
  always_comb begin
    digit     = $signed({1'b0, in_ch}) - $signed({1'b0, CH_ZERO});
    digit_abs = digit[8] ? 8'(-digit) : digit[7:0];
    msb       = '0;
    for (int i = 0; i < 8; i++) begin
      if (digit_abs[i]) begin
        msb = 3'(i);
      end
    end
    frac_sh = {16'b0, digit_abs} << (5'd23 - {2'b0, msb});
    if (digit_abs == '0) begin
      digf = F_ZERO;
    end else begin
      digf = {digit[8], 8'(8'd127 + {5'b0, msb}), frac_sh[22:0]};
    end
  end

  // exponent magnitude, exact and clamped
  always_comb begin
    mag_ext = MW'(mag_r);
    m_calc  = $signed((mag_ext << 3) + (mag_ext << 1)) + MW'(digit);
    if (m_calc < 0) begin
      mag_upd = '0;
    end else if (m_calc > SAT_S) begin
      mag_upd = MAG_W'(EXP_SATURATE);
    end else begin
      mag_upd = m_calc[MAG_W-1:0];
    end
  end

  // classification
  always_comb begin
    op         = OP_NONE;
    neg_nxt    = neg_r;
    in_exp_nxt = in_exp_r;
    eneg_nxt   = eneg_r;
    mag_nxt    = mag_r;
    if (!in_exp_r) begin
      if (in_ch == CH_PLUS) begin
        op = OP_NONE;
      end else if (in_ch == CH_MINUS) begin
        neg_nxt = 1'b1;
      end else if (in_ch == CH_DOT) begin
        op = OP_DOT;
      end else if (in_ch == CH_E_LO || in_ch == CH_E_UP) begin
        op         = OP_EXP;
        in_exp_nxt = 1'b1;
      end else begin
        op = OP_DIGIT;
      end
    end else begin
      if (in_ch == CH_PLUS) begin
        op = OP_NONE;
      end else if (in_ch == CH_MINUS) begin
        eneg_nxt = 1'b1;
      end else begin
        mag_nxt = mag_upd;
      end
    end
  end

  // queue write
  always_comb begin
    q_push_o        = accept;
    q_data_o.op     = op;
    q_data_o.digf   = digf;
    q_data_o.last   = in_last;
    q_data_o.neg    = neg_nxt;
    q_data_o.in_exp = in_exp_nxt;
    q_data_o.eneg   = eneg_nxt;
    q_data_o.mag    = Q_MAG_W'(mag_nxt);
  end

  // per number state, cleared after the last character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r    <= 1'b0;
      in_exp_r <= 1'b0;
      eneg_r   <= 1'b0;
      mag_r    <= '0;
    end else if (accept) begin
      if (in_last) begin
        neg_r    <= 1'b0;
        in_exp_r <= 1'b0;
        eneg_r   <= 1'b0;
        mag_r    <= '0;
      end else begin
        neg_r    <= neg_nxt;
        in_exp_r <= in_exp_nxt;
        eneg_r   <= eneg_nxt;
        mag_r    <= mag_nxt;
      end
    end
  end

endmodule

@@ design/dtf_fpu.sv @@
// three stage single precision multiply and add, round to nearest even
`timescale 1ns / 1ps

module dtf_fpu (
  input  logic              clk,
  input  logic              rst_n,
  input  dtf_pkg::fpu_req_t req_i,
  output logic              done_o,
  output logic [31:0]       res_o
);
  import dtf_pkg::*;

  // stage one registers
  logic               v1_r;
  logic               sp1_r;
  logic [31:0]        spv1_r;
  logic               s1_r;
  logic signed [10:0] e1_r;
  logic [47:0]        r1_r;
  // stage two registers
  logic               v2_r;
  logic               sp2_r;
  logic [31:0]        spv2_r;
  logic               s2_r;
  logic signed [10:0] e2_r;
  logic [47:0]        r2_r;
  logic [5:0]         lz2_r;
  // stage three registers
  logic               done_r;
  logic [31:0]        res_r;

  logic               sp1_nxt;
  logic [31:0]        spv1_nxt;
  logic               s1_nxt;
  logic signed [10:0] e1_nxt;
  logic [47:0]        r1_nxt;
  logic [5:0]         lz_nxt;
  logic [31:0]        res_nxt;

  logic        sa, sb;
  logic [7:0]  ea, eb, fa_e, fb_e, d;
  logic [23:0] ma, mb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [31:0] big, sml;
  logic [7:0]  big_e, sml_e;
  logic [23:0] big_m, sml_m;
  logic [47:0] rl, xs, rs;
  logic        st_a;

  assign done_o = done_r;
  assign res_o  = res_r;

  // unpack, special cases, raw product or aligned sum
  always_comb begin
    sa     = req_i.a[31];
    sb     = req_i.b[31];
    ea     = req_i.a[30:23];
    eb     = req_i.b[30:23];
    a_nan  = (ea == 8'hFF) && (req_i.a[22:0] != '0);
    b_nan  = (eb == 8'hFF) && (req_i.b[22:0] != '0);
    a_inf  = (ea == 8'hFF) && (req_i.a[22:0] == '0);
    b_inf  = (eb == 8'hFF) && (req_i.b[22:0] == '0);
    a_zero = (req_i.a[30:0] == '0);
    b_zero = (req_i.b[30:0] == '0);
    fa_e   = (ea == '0) ? 8'd1 : ea;
    fb_e   = (eb == '0) ? 8'd1 : eb;
    ma     = {(ea != '0), req_i.a[22:0]};
    mb     = {(eb != '0), req_i.b[22:0]};
    sp1_nxt  = 1'b0;
    spv1_nxt = F_ZERO;
    s1_nxt   = 1'b0;
    e1_nxt   = '0;
    r1_nxt   = '0;
    big   = req_i.a;
    sml   = req_i.b;
    big_e = fa_e;
    sml_e = fb_e;
    big_m = ma;
    sml_m = mb;
    d     = '0;
    rl    = '0;
    xs    = '0;
    rs    = '0;
    st_a  = 1'b0;
    case (req_i.op)
      FOP_MUL: begin
        s1_nxt = sa ^ sb;
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
          sp1_nxt  = 1'b1;
          spv1_nxt = F_QNAN;
        end else if (a_inf || b_inf) begin
          sp1_nxt  = 1'b1;
          spv1_nxt = {sa ^ sb, 8'hFF, 23'b0};
        end else if (a_zero || b_zero) begin
          sp1_nxt  = 1'b1;
          spv1_nxt = {sa ^ sb, 31'b0};
        end
        r1_nxt = ma * mb;
        e1_nxt = $signed({3'b0, fa_e}) + $signed({3'b0, fb_e}) - 11'sd126;
      end
      FOP_ADD: begin
        if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) begin
          sp1_nxt  = 1'b1;
          spv1_nxt = F_QNAN;
        end else if (a_inf) begin
          sp1_nxt  = 1'b1;
          spv1_nxt = req_i.a;
        end else if (b_inf) begin
          sp1_nxt  = 1'b1;
          spv1_nxt = req_i.b;
        end else if (a_zero && b_zero) begin
          sp1_nxt  = 1'b1;
          spv1_nxt = {sa & sb, 31'b0};
        end else if (a_zero) begin
          sp1_nxt  = 1'b1;
          spv1_nxt = req_i.b;
        end else if (b_zero) begin
          sp1_nxt  = 1'b1;
          spv1_nxt = req_i.a;
        end
        // larger magnitude first
        if (req_i.b[30:0] > req_i.a[30:0]) begin
          big   = req_i.b;
          sml   = req_i.a;
          big_e = fb_e;
          sml_e = fa_e;
          big_m = mb;
          sml_m = ma;
        end
        d  = big_e - sml_e;
        rl = {1'b0, big_m, 23'b0};
        xs = {1'b0, sml_m, 23'b0};
        if (d >= 8'd48) begin
          rs   = '0;
          st_a = 1'b1;
        end else begin
          rs   = xs >> d[5:0];
          st_a = |(xs & ~({48{1'b1}} << d[5:0]));
        end
        rs[0]  = rs[0] | st_a;
        s1_nxt = big[31];
        r1_nxt = (big[31] == sml[31]) ? rl + rs : rl - rs;
        e1_nxt = $signed({3'b0, big_e}) + 11'sd1;
      end
      default: begin
        sp1_nxt  = 1'b1;
        spv1_nxt = F_QNAN;
      end
    endcase
  end

  // leading zero count
  always_comb begin
    lz_nxt = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (r1_r[i]) begin
        lz_nxt = 6'(47 - i);
      end
    end
  end

  // normalise, round and pack
  always_comb begin
    logic signed [10:0] en;
    logic signed [10:0] ef;
    logic [10:0]        k;
    logic [47:0]        n;
    logic               st0, grd, st, inc;
    logic [30:0]        mag;
    en  = e2_r - $signed({5'b0, lz2_r});
    ef  = '0;
    k   = '0;
    n   = '0;
    st0 = 1'b0;
    grd = 1'b0;
    st  = 1'b0;
    inc = 1'b0;
    mag = '0;
    if (sp2_r) begin
      res_nxt = spv2_r;
    end else if (lz2_r == 6'd48) begin
      res_nxt = F_ZERO;
    end else begin
      if (en >= 11'sd1) begin
        n  = r2_r << lz2_r;
        ef = en;
      end else if (e2_r >= 11'sd1) begin
        k  = 11'(e2_r - 11'sd1);
        n  = r2_r << k[5:0];
        ef = '0;
      end else begin
        k = 11'(11'sd1 - e2_r);
        if (k > 11'd48) begin
          k = 11'd48;
        end
        n   = (k == 11'd48) ? '0 : (r2_r >> k[5:0]);
        st0 = (k == 11'd48) ? 1'b1 : |(r2_r & ~({48{1'b1}} << k[5:0]));
        ef  = '0;
      end
      grd = n[23];
      st  = st0 | (|n[22:0]);
      inc = grd & (st | n[24]);
      mag = {ef[7:0], n[46:24]} + {30'b0, inc};
      if (ef >= 11'sd255) begin
        res_nxt = {s2_r, 8'hFF, 23'b0};
      end else begin
        res_nxt = {s2_r, mag};
      end
    end
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= req_i.valid;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  // data pipeline
  always_ff @(posedge clk) begin
    sp1_r  <= sp1_nxt;
    spv1_r <= spv1_nxt;
    s1_r   <= s1_nxt;
    e1_r   <= e1_nxt;
    r1_r   <= r1_nxt;
    sp2_r  <= sp1_r;
    spv2_r <= spv1_r;
    s2_r   <= s1_r;
    e2_r   <= e1_r;
    r2_r   <= r1_r;
    lz2_r  <= lz_nxt;
    res_r  <= res_nxt;
  end

endmodule

@@ design/dtf_back.sv @@
// back end: float sequencer for digits, power of ten and the final product
`timescale 1ns / 1ps

module dtf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty_i,
  input  dtf_pkg::q_entry_t     q_head_i,
  output logic                  q_pop_o,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_result_bits
);
  import dtf_pkg::*;

  bk_state_t           state_r, state_nxt;
  bk_state_t           ret_r, ret_nxt;
  q_entry_t            cur_r, cur_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic [31:0]         scale_r, scale_nxt;
  logic [31:0]         tmp_r, tmp_nxt;
  logic [31:0]         x_r, x_nxt;
  logic [31:0]         y_r, y_nxt;
  logic [Q_MAG_W-1:0]  m_r, m_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_bits_r, out_bits_nxt;

  fpu_req_t    req;
  logic        fpu_done;
  logic [31:0] fpu_res;
  logic [31:0] factor;
  logic        tmp_nan;

  assign out_valid       = out_valid_r;
  assign out_result_bits = out_bits_r;

  dtf_fpu u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (req),
    .done_o (fpu_done),
    .res_o  (fpu_res)
  );

  assign factor  = (tmp_r[30:0] == '0) ? F_ONE : tmp_r;
  assign tmp_nan = (tmp_r[30:23] == 8'hFF) && (tmp_r[22:0] != '0);

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_r;
    scale_nxt     = scale_r;
    tmp_nxt       = tmp_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    m_nxt         = m_r;
    out_valid_nxt = out_valid_r;
    out_bits_nxt  = out_bits_r;
    q_pop_o       = 1'b0;
    req.valid     = 1'b0;
    req.op        = FOP_MUL;
    req.a         = acc_r;
    req.b         = F_TEN;

    // output beat taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          cur_nxt   = q_head_i;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cur_r.op)
          OP_DIGIT: begin
            req.valid = 1'b1;
            req.op    = FOP_MUL;
            req.a     = acc_r;
            req.b     = F_TEN;
            ret_nxt   = S_D_ADD;
            state_nxt = S_WAIT;
          end
          OP_DOT: begin
            scale_nxt = F_ONE;
            state_nxt = S_CHK;
          end
          OP_EXP: begin
            if (scale_r[30:0] == '0) begin
              scale_nxt = F_ONE;
            end
            state_nxt = S_CHK;
          end
          default: begin
            state_nxt = S_CHK;
          end
        endcase
      end
      S_WAIT: begin
        if (fpu_done) begin
          tmp_nxt   = fpu_res;
          state_nxt = ret_r;
        end
      end
      S_D_ADD: begin
        req.valid = 1'b1;
        req.op    = FOP_ADD;
        req.a     = tmp_r;
        req.b     = cur_r.digf;
        ret_nxt   = S_D_SCL;
        state_nxt = S_WAIT;
      end
      S_D_SCL: begin
        acc_nxt   = tmp_r;
        req.valid = 1'b1;
        req.op    = FOP_MUL;
        req.a     = scale_r;
        req.b     = F_TENTH;
        ret_nxt   = S_D_END;
        state_nxt = S_WAIT;
      end
      S_D_END: begin
        scale_nxt = tmp_r;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!cur_r.last) begin
          state_nxt = S_IDLE;
        end else if (cur_r.in_exp) begin
          y_nxt     = F_ONE;
          x_nxt     = (cur_r.mag == '0) ? F_ONE : (cur_r.eneg ? F_TENTH : F_TEN);
          m_nxt     = cur_r.mag;
          state_nxt = S_P_LOOP;
        end else begin
          tmp_nxt   = scale_r;
          state_nxt = S_F_ZERO;
        end
      end
      // square and multiply over the exponent bits
      S_P_LOOP: begin
        req.valid = 1'b1;
        req.op    = FOP_MUL;
        state_nxt = S_WAIT;
        if (m_r > Q_MAG_W'(1)) begin
          if (m_r[0]) begin
            req.a   = y_r;
            req.b   = x_r;
            ret_nxt = S_P_Y;
          end else begin
            req.a   = x_r;
            req.b   = x_r;
            ret_nxt = S_P_X;
          end
        end else begin
          req.a   = x_r;
          req.b   = y_r;
          ret_nxt = S_P_END;
        end
      end
      S_P_Y: begin
        y_nxt     = tmp_r;
        req.valid = 1'b1;
        req.op    = FOP_MUL;
        req.a     = x_r;
        req.b     = x_r;
        ret_nxt   = S_P_X;
        state_nxt = S_WAIT;
      end
      S_P_X: begin
        x_nxt     = tmp_r;
        m_nxt     = m_r >> 1;
        state_nxt = S_P_LOOP;
      end
      S_P_END: begin
        req.valid = 1'b1;
        req.op    = FOP_MUL;
        req.a     = scale_r;
        req.b     = tmp_r;
        ret_nxt   = S_F_ZERO;
        state_nxt = S_WAIT;
      end
      // zero factor stands for one, then signed mantissa times factor
      S_F_ZERO: begin
        req.valid = 1'b1;
        req.op    = FOP_MUL;
        req.a     = {acc_r[31] ^ cur_r.neg, acc_r[30:0]};
        req.b     = factor;
        ret_nxt   = S_OUT;
        state_nxt = S_WAIT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_bits_nxt  = tmp_nan ? F_QNAN : tmp_r;
          acc_nxt       = F_ZERO;
          scale_nxt     = F_ZERO;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= F_ZERO;
      scale_r     <= F_ZERO;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      scale_r     <= scale_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    tmp_r      <= tmp_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    m_r        <= m_nxt;
    out_bits_r <= out_bits_nxt;
  end

endmodule

@@ design/decimal_text_to_float.sv @@
// top level: decimal text in, one single precision value per number out
//
//   channel | ports                         | beat
//   in      | in_valid in_stall in_ch       | one character, in_last ends it
//           | in_last                       |
//   out     | out_valid out_stall           | one result per number
//           | out_result_bits               |
//
// a digit character takes three float operations in the back end, each an
// issue plus the three stage float unit, besides pop, dispatch and check;
// other characters take only pop, dispatch and check. the last character adds
// the final multiply and the output step; with an exponent it also adds a
// squaring per exponent bit below the top one, one more multiply per set bit
// there, and two further multiplies. the front end keeps taking characters
// into a four deep queue while the back end works. reset is synchronous and
// clears all control state. a stalled result is held in the output register.
`timescale 1ns / 1ps

module decimal_text_to_float #(
  parameter int unsigned EXP_SATURATE = 255,
  parameter int unsigned Q_DEPTH      = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_bits
);
  import dtf_pkg::*;

  logic     q_push, q_pop, q_full, q_empty;
  q_entry_t q_wdata, q_head;

  dtf_front #(
    .EXP_SATURATE (EXP_SATURATE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_ch    (in_ch),
    .in_last  (in_last),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  dtf_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  dtf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty_i       (q_empty),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_bits (out_result_bits)
  );

endmodule

@@ tb/tb.sv @@
// testbench for decimal_text_to_float: directed and random numbers checked against a float model
`timescale 1ns / 1ps

module tb;
  import dtf_pkg::*;

  localparam logic [31:0] F_MINUS_ONE = 32'hBF80_0000;
  localparam int unsigned MAG_LIMIT = 255;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_ch;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_result_bits;

  // converter state mirrored by the predictor
  logic [31:0] acc_f;
  logic [31:0] scale_f;
  logic        mant_neg;
  logic        exp_mode;
  int          exp_mag;
  logic        exp_neg;

  logic [31:0] expected_values[$];
  int          err_cnt;
  int          idle_pct;
  int          stall_pct;

  decimal_text_to_float i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch          (in_ch),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_bits(out_result_bits)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // round to nearest-even and pack: value is sig * 2^e2 exactly
  function automatic logic [31:0] fpack(logic s, int e2, logic [127:0] sig);
    int           p;
    int           sh;
    int           be;
    logic [255:0] w;
    logic [127:0] keep;
    logic         g;
    logic         st;
    if (sig == 0) return {s, 31'b0};
    p = 127;
    while (!sig[p]) p--;
    sh = p - 23;
    if (sh < -149 - e2) sh = -149 - e2;
    if (sh >= 130) begin
      keep = 0;
    end else if (sh > 0) begin
      w    = {sig, 128'b0} >> sh;
      keep = w[255:128];
      g    = w[127];
      st   = |w[126:0];
      if (g && (st || keep[0])) keep++;
      if (keep[24]) begin
        keep = keep >> 1;
        sh++;
      end
    end else begin
      keep = sig << (-sh);
    end
    if (keep[23]) begin
      be = sh + e2 + 150;
      if (be >= 255) return {s, 8'hFF, 23'b0};
      return {s, be[7:0], keep[22:0]};
    end
    return {s, 8'b0, keep[22:0]};
  endfunction

  function automatic logic f_is_nan(logic [31:0] f);
    return f[30:23] == 8'hFF && f[22:0] != 0;
  endfunction

  function automatic logic f_is_inf(logic [31:0] f);
    return f[30:23] == 8'hFF && f[22:0] == 0;
  endfunction

  function automatic int f_exp(logic [31:0] f);
    return (f[30:23] == 0) ? 1 : int'(f[30:23]);
  endfunction

  function automatic logic [23:0] f_sig(logic [31:0] f);
    return {f[30:23] != 0, f[22:0]};
  endfunction

  // single precision multiply
  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    logic s;
    s = a[31] ^ b[31];
    if (f_is_nan(a) || f_is_nan(b)) return F_QNAN;
    if (f_is_inf(a) || f_is_inf(b)) begin
      if (a[30:0] == 0 || b[30:0] == 0) return F_QNAN;
      return {s, 8'hFF, 23'b0};
    end
    return fpack(s, f_exp(a) + f_exp(b) - 300, 128'(f_sig(a)) * 128'(f_sig(b)));
  endfunction

  // single precision add
  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    logic [31:0]  t;
    logic [127:0] big;
    logic [127:0] sm;
    logic [127:0] r;
    logic         s;
    int           d;
    int           e2;
    if (f_is_nan(a) || f_is_nan(b)) return F_QNAN;
    if (f_is_inf(a) && f_is_inf(b)) return (a[31] != b[31]) ? F_QNAN : a;
    if (f_is_inf(a)) return a;
    if (f_is_inf(b)) return b;
    if (f_exp(b) > f_exp(a)) begin
      t = a;
      a = b;
      b = t;
    end
    d = f_exp(a) - f_exp(b);
    if (d >= 64) begin
      // far smaller operand only leaves a sticky bit
      big = 128'(f_sig(a)) << 40;
      sm  = (f_sig(b) != 0) ? 128'd1 : 128'd0;
      e2  = f_exp(a) - 190;
    end else begin
      big = 128'(f_sig(a)) << d;
      sm  = 128'(f_sig(b));
      e2  = f_exp(b) - 150;
    end
    if (a[31] == b[31]) begin
      r = big + sm;
      s = a[31];
    end else if (big >= sm) begin
      r = big - sm;
      s = a[31];
    end else begin
      r = sm - big;
      s = b[31];
    end
    if (r == 0) s = a[31] & b[31];
    return fpack(s, e2, r);
  endfunction

  // ten to the power of the exponent by square-and-multiply
  function automatic logic [31:0] pow_ten(int mag, logic neg);
    logic [31:0] y;
    logic [31:0] x;
    int          m;
    y = F_ONE;
    x = (mag == 0) ? F_ONE : (neg ? F_TENTH : F_TEN);
    m = mag;
    while (m > 1) begin
      if (m[0]) y = fmul(y, x);
      x = fmul(x, x);
      m = m >> 1;
    end
    return fmul(x, y);
  endfunction

  task automatic clear_number();
    acc_f    = F_ZERO;
    scale_f  = F_ZERO;
    mant_neg = 1'b0;
    exp_mode = 1'b0;
    exp_mag  = 0;
    exp_neg  = 1'b0;
  endtask

  // advance the parser on one accepted character, queue the value on the last one
  task automatic convert_char(logic [7:0] c, logic fin);
    int          dig;
    int          m;
    logic [31:0] fct;
    logic [31:0] v;
    dig = int'(c) - int'(CH_ZERO);
    if (!exp_mode) begin
      if (c == CH_MINUS) begin
        mant_neg = 1'b1;
      end else if (c == CH_DOT) begin
        scale_f = F_ONE;
      end else if (c == CH_E_LO || c == CH_E_UP) begin
        if (scale_f[30:0] == 0) scale_f = F_ONE;
        exp_mode = 1'b1;
      end else if (c != CH_PLUS) begin
        acc_f   = fadd(fmul(F_TEN, acc_f), fpack(dig < 0, 0, 128'(dig < 0 ? -dig : dig)));
        scale_f = fmul(scale_f, F_TENTH);
      end
    end else begin
      if (c == CH_MINUS) begin
        exp_neg = 1'b1;
      end else if (c != CH_PLUS) begin
        m = exp_mag * 10 + dig;
        if (m < 0) m = 0;
        if (m > MAG_LIMIT) m = MAG_LIMIT;
        exp_mag = m;
      end
    end
    if (fin) begin
      fct = scale_f;
      if (exp_mode) fct = fmul(fct, pow_ten(exp_mag, exp_neg));
      if (fct[30:0] == 0) fct = F_ONE;
      v = fmul(fmul(mant_neg ? F_MINUS_ONE : F_ONE, acc_f), fct);
      expected_values.push_back(f_is_nan(v) ? F_QNAN : v);
      clear_number();
    end
  endtask

  // send one character beat, with random sender idling
  task automatic send_char(logic [7:0] c, logic fin);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    in_last  <= fin;
    do @(posedge clk); while (in_stall);
    convert_char(c, fin);
  endtask

  task automatic send_text(string txt);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    release_input();
    while (expected_values.size() != 0) @(posedge clk);
  endtask

  // receiver stalling
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time,
                 out_result_bits);
        err_cnt++;
      end else begin
        if (out_result_bits !== expected_values[0]) begin
          $display("%0t: result_bits mismatch, expected %h, actual %h", $time,
                   expected_values[0], out_result_bits);
          err_cnt++;
        end
        void'(expected_values.pop_front());
      end
    end
  end

  // one random character sequence: mostly well-formed numbers, some noise
  task automatic send_random_number(output int n_sent);
    logic [7:0] txt[$];
    int         n;
    if ($urandom_range(99) < 12) begin
      n = $urandom_range(6, 1);
      repeat (n) txt.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(2) == 0) txt.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
      n = $urandom_range(8);
      repeat (n) txt.push_back(8'(CH_ZERO + $urandom_range(9)));
      if ($urandom_range(1)) begin
        txt.push_back(CH_DOT);
        repeat ($urandom_range(6)) txt.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
      if ($urandom_range(2) == 0) begin
        txt.push_back($urandom_range(1) ? CH_E_LO : CH_E_UP);
        if ($urandom_range(1)) txt.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
        repeat ($urandom_range(3, 1)) txt.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
      if (txt.size() == 0) txt.push_back(8'(CH_ZERO + $urandom_range(9)));
      // occasional stray byte inside an otherwise valid number
      if ($urandom_range(19) == 0) txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
    end
    foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
    n_sent = txt.size();
  endtask

  task automatic run_random(int n_chars, int idle, int stall);
    int sent;
    int k;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < n_chars) begin
      send_random_number(k);
      sent += k;
    end
    wait_drained();
  endtask

  // extremes, signs, overflow, zero times infinity, scale underflow, odd bytes
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_text("-0");
    send_text("9.5");
    send_text("1e39");
    send_text("0E99");
    send_text("5e-99");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_text("e!");
    send_text("1e.e");
    wait_drained();
  endtask

  // sender holds off until every value is back, then resumes
  task automatic test_hold_off();
    idle_pct  = 0;
    stall_pct = 21;
    send_text("12.5e-3");
    wait_drained();
    repeat (20) @(posedge clk);
    send_text("-3.25E+2");
    wait_drained();
  endtask

  task automatic test_no_idle();
    run_random(240, 0, 0);
  endtask

  task automatic test_sender_idle();
    run_random(230, 87, 0);
  endtask

  task automatic test_receiver_stall();
    run_random(230, 0, 87);
  endtask

  task automatic test_both_idle();
    run_random(230, 21, 21);
  endtask

  // main sequence
  initial begin
    err_cnt   = 0;
    idle_pct  = 0;
    stall_pct = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_ch     = 8'h00;
    in_last   = 1'b0;
    out_stall = 1'b0;
    clear_number();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_hold_off();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    stall_pct = 0;
    repeat (200) @(posedge clk);
    if (err_cnt == 0) begin
      $display("decimal_text_to_float test passed");
    end else begin
      $display("decimal_text_to_float test failed");
    end
    $finish;
  end

  // run time limit
  initial begin
    #5_000_000;
    $display("decimal_text_to_float test failed");
    $finish;
  end

endmodule

@@ files.f @@
design/dtf_pkg.sv
design/dtf_queue.sv
design/dtf_front.sv
design/dtf_fpu.sv
design/dtf_back.sv
design/decimal_text_to_float.sv
tb/tb.sv
